[rtl/button_press_classifier_assert.svh]
// Assertion macros shared by the button press classifier RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// Package for the button press classifier: sizes, query codes, per-button entry.
// No dependencies; used by button_press_classifier and its testbench.
`default_nettype none

package bpc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int BIDX_W      = 3;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd500;

    typedef enum logic [1:0] {
        ACT_SHORT = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_HELD  = 2'd2
    } action_t;

    typedef struct packed {
        logic              pressed;
        logic [TIME_W-1:0] press_start;
        logic              held;
        logic [TIME_W-1:0] hold_start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/bpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/button_press_classifier.sv]
// Button press classifier top level: per-button state in a RAM, read-modify-write.
// Depends on bpc_pkg, bpc_ram and button_press_classifier_assert.svh.
//
// Usage:
//   Input stream s_axis: one transfer is one query on one active-low button.
//     tuser selects the query (short press on release, press edge, held),
//     tdata carries the button index, the raw pin level and the millisecond time.
//   Output stream m_axis: exactly one transfer per input transfer, in order,
//     tdata bit 0 is the event flag.
//   Configuration: cfg_we writes cfg_wdata into the hold threshold (ms) at the
//     clock edge; write only while no query is in flight.
//   Pipeline: the query is registered into the update stage as its RAM entry is read,
//     and the update stage then loads the result register.
//     Throughput: one query per cycle while the output is not stalled, with a single
//     update stage; a write-back forwarding register covers same-button queries.
//   Reset: the threshold returns to 500 ms and every button reads as all zero
//     (per-entry valid bits, no clearing pass); queries are taken at once.
//   Stall: the result register holds while m_axis_tready is low; one more query
//     waits in the update stage, then s_axis_tready drops until the output drains.
`default_nettype none

`include "button_press_classifier_assert.svh"

module button_press_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [2:0] button_index, [3] pin_level,
                                            // [35:4] now_ms, [39:36] zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [0] event_res, [7:1] zero
);

    localparam int AW   = bpc_pkg::ADDR_W;
    localparam int BW   = bpc_pkg::BIDX_W;
    localparam int TW   = bpc_pkg::TIME_W;
    localparam int NB_W = bpc_pkg::NUM_BUTTONS;

    // Configuration
    logic [bpc_pkg::THR_W-1:0] thr_reg;

    // Input field split
    logic [BW-1:0] in_idx;
    logic          in_pin;
    logic [TW-1:0] in_now;
    logic [AW-1:0] in_addr;
    logic [BW+AW-1:0] in_idx_ext;
    logic          in_xfer;

    // Update stage
    logic                s1_valid_reg;
    bpc_pkg::action_t    s1_action_reg;
    logic [BW-1:0]       s1_idx_reg;
    logic                s1_pin_reg;
    logic [TW-1:0]       s1_now_reg;
    logic [AW-1:0]       s1_addr;
    logic [BW+AW-1:0]    s1_idx_ext;
    logic                s1_in_range;
    logic                s1_adv;

    // Storage and forwarding
    logic [NB_W-1:0]     entry_valid_reg;
    logic                fwd_valid_reg;
    logic [AW-1:0]       fwd_addr_reg;
    bpc_pkg::entry_t     fwd_data_reg;
    logic [bpc_pkg::ENTRY_W-1:0] ram_rdata;
    bpc_pkg::entry_t     cur;
    bpc_pkg::entry_t     upd;
    logic                ram_we;
    logic                hit;
    logic                down;
    logic [TW-1:0]       hs_eff;
    logic [TW-1:0]       press_diff;
    logic [TW-1:0]       hold_diff;
    logic [TW-1:0]       thr_ext;

    // Result register
    logic                out_valid_reg;
    logic                out_event_reg;

    assign in_idx     = s_axis_tdata[2:0];
    assign in_pin     = s_axis_tdata[3];
    assign in_now     = s_axis_tdata[35:4];
    assign in_idx_ext = {{AW{1'b0}}, in_idx};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign in_xfer    = s_axis_tvalid && s_axis_tready;

    // Advance the update stage when the result register is free or draining.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= bpc_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Read the entry as the query is taken; data shows up in the update stage.
    bpc_ram #(
        .WIDTH (bpc_pkg::ENTRY_W),
        .DEPTH (bpc_pkg::NUM_BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (upd),
        .re    (in_xfer),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_action_reg <= bpc_pkg::action_t'(s_axis_tuser);
            s1_idx_reg    <= in_idx;
            s1_pin_reg    <= in_pin;
            s1_now_reg    <= in_now;
        end
    end

    assign s1_idx_ext  = {{AW{1'b0}}, s1_idx_reg};
    assign s1_addr     = s1_idx_ext[AW-1:0];
    assign s1_in_range = (int'(s1_idx_reg) < bpc_pkg::NUM_BUTTONS);

    // Pick the newest copy of the entry: last write-back, else RAM, else reset value.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            cur = fwd_data_reg;
        end
        else if (s1_in_range && entry_valid_reg[s1_addr])
        begin
            cur = bpc_pkg::entry_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    assign down       = !s1_pin_reg;
    assign thr_ext    = {{(TW - bpc_pkg::THR_W){1'b0}}, thr_reg};
    assign press_diff = s1_now_reg - cur.press_start;
    assign hs_eff     = (cur.hold_start == '0) ? s1_now_reg : cur.hold_start;
    assign hold_diff  = s1_now_reg - hs_eff;

    // Classify and build the written-back entry.
    always_comb
    begin
        upd    = cur;
        hit    = 1'b0;
        ram_we = 1'b0;
        if (s1_adv && s1_in_range)
        begin
            case (s1_action_reg)
                bpc_pkg::ACT_SHORT:
                begin
                    ram_we = 1'b1;
                    if (down)
                    begin
                        upd.pressed = 1'b1;
                        if (cur.press_start == '0)
                        begin
                            upd.press_start = s1_now_reg;
                        end
                    end
                    else
                    begin
                        hit             = (press_diff < thr_ext) && cur.pressed;
                        upd.pressed     = 1'b0;
                        upd.press_start = '0;
                    end
                end
                bpc_pkg::ACT_EDGE:
                begin
                    ram_we      = 1'b1;
                    upd.pressed = down;
                    hit         = down && !cur.pressed;
                end
                bpc_pkg::ACT_HELD:
                begin
                    ram_we = 1'b1;
                    if (down)
                    begin
                        if ((hold_diff > thr_ext) && !cur.held)
                        begin
                            upd.hold_start = '0;
                            upd.held       = 1'b1;
                            hit            = 1'b1;
                        end
                        else
                        begin
                            upd.hold_start = hs_eff;
                        end
                    end
                    else
                    begin
                        upd.hold_start = '0;
                        upd.held       = 1'b0;
                    end
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // Mark written entries and hold the last write-back for the next query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else if (ram_we)
        begin
            entry_valid_reg[s1_addr] <= 1'b1;
            fwd_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= upd;
        end
    end

    // Result register: load on advance, drop after the output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_event_reg <= hit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_event_reg};

    `BPC_ASSERT_NXT(a_adv_loads_out, clk, rst_n, s1_adv, m_axis_tvalid,
        "advanced query left no result")
    `BPC_ASSERT_IMP(a_ready_only_blocked, clk, rst_n, !s_axis_tready,
        s1_valid_reg && out_valid_reg && !m_axis_tready,
        "input stalled without a blocked result")
    `BPC_ASSERT_IMP(a_we_needs_adv, clk, rst_n, ram_we, s1_adv && s1_in_range,
        "state written without an advancing query")
    `BPC_ASSERT_NXT(a_fwd_tracks_write, clk, rst_n, ram_we,
        fwd_valid_reg && (fwd_addr_reg == $past(s1_addr)) && entry_valid_reg[$past(s1_addr)],
        "write-back not captured for forwarding")
    `BPC_ASSERT_IMP(a_edge_sets_pressed, clk, rst_n,
        hit && (s1_action_reg == bpc_pkg::ACT_EDGE), upd.pressed && ram_we,
        "press edge reported without setting the pressed flag")

endmodule

`default_nettype wire

[bench/tb_button_press_classifier.sv]
// Testbench for button_press_classifier: directed queries, then random press
// sequences under several hold thresholds and idle patterns, checked in order.
// Depends on bpc_pkg and the button_press_classifier RTL.

module tb_button_press_classifier;

    // Action code 3 is not a query; the block must answer it with no event.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int STALL_LIMIT       = 4000;
    localparam int RANDOM_PHASES     = 8;
    localparam int QUERIES_PER_PHASE = 136;

    typedef struct packed {
        logic [1:0]                 action;
        logic [bpc_pkg::BIDX_W-1:0] button;
        logic                       pin_level;
        logic [bpc_pkg::TIME_W-1:0] now_ms;
    } query_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    // Predicted per-button state and the hold threshold, in the block's widths.
    logic                       btn_pressed  [bpc_pkg::NUM_BUTTONS];
    logic [bpc_pkg::TIME_W-1:0] btn_press_t  [bpc_pkg::NUM_BUTTONS];
    logic                       btn_held     [bpc_pkg::NUM_BUTTONS];
    logic [bpc_pkg::TIME_W-1:0] btn_hold_t   [bpc_pkg::NUM_BUTTONS];
    logic [bpc_pkg::THR_W-1:0]  hold_thr_ms;

    // Stimulus side: millisecond clock kept per button for well-formed sequences.
    logic [bpc_pkg::TIME_W-1:0] btn_clock    [bpc_pkg::NUM_BUTTONS];

    query_t pending_queries[$];
    logic   expected_events[$];
    query_t in_flight;
    logic [7:0] expected_byte;

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int queries_queued   = 0;
    int queries_accepted = 0;
    int results_seen     = 0;
    int events_seen      = 0;
    int error_count      = 0;
    int idle_cycles      = 0;
    int thresholds_used  = 1;

    button_press_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one query to the predicted state and return its event bit.
    function automatic logic classify_query(query_t q);
        logic                       down;
        logic                       hit;
        logic [bpc_pkg::TIME_W-1:0] elapsed;
        down = (q.pin_level == 1'b0);
        hit  = 1'b0;
        if (q.button < bpc_pkg::NUM_BUTTONS)
        begin
            case (q.action)
                bpc_pkg::ACT_SHORT:
                begin
                    if (down)
                    begin
                        btn_pressed[q.button] = 1'b1;
                        if (btn_press_t[q.button] == '0)
                            btn_press_t[q.button] = q.now_ms;
                    end
                    else
                    begin
                        elapsed = q.now_ms - btn_press_t[q.button];
                        hit = (elapsed < {16'd0, hold_thr_ms}) && btn_pressed[q.button];
                        btn_pressed[q.button] = 1'b0;
                        btn_press_t[q.button] = '0;
                    end
                end
                bpc_pkg::ACT_EDGE:
                begin
                    if (down)
                    begin
                        hit = !btn_pressed[q.button];
                        btn_pressed[q.button] = 1'b1;
                    end
                    else
                        btn_pressed[q.button] = 1'b0;
                end
                bpc_pkg::ACT_HELD:
                begin
                    if (down)
                    begin
                        if (btn_hold_t[q.button] == '0)
                            btn_hold_t[q.button] = q.now_ms;
                        elapsed = q.now_ms - btn_hold_t[q.button];
                        // Fire once; the start goes back to unset but held stays up.
                        if (elapsed > {16'd0, hold_thr_ms} && !btn_held[q.button])
                        begin
                            btn_hold_t[q.button] = '0;
                            btn_held[q.button]   = 1'b1;
                            hit = 1'b1;
                        end
                    end
                    else
                    begin
                        btn_hold_t[q.button] = '0;
                        btn_held[q.button]   = 1'b0;
                    end
                end
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    // Offset from a press start: zero, on or next to the hold threshold, or random up to twice it plus two.
    function automatic logic [bpc_pkg::TIME_W-1:0] near_threshold(
            logic [bpc_pkg::THR_W-1:0] thr);
        logic [bpc_pkg::TIME_W-1:0] t;
        t = {16'd0, thr};
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return t - 1;
            2:       return t;
            3:       return t + 1;
            default: return $urandom_range(0, 2 * int'(thr) + 2);
        endcase
    endfunction

    function automatic logic [1:0] pick_action(logic [1:0] main_action);
        if ($urandom_range(0, 99) < 85)
            return main_action;
        return 2'($urandom_range(0, 3));
    endfunction

    task automatic add_query(logic [1:0] act, int btn, logic pin,
                             logic [bpc_pkg::TIME_W-1:0] now);
        query_t q;
        q.action    = act;
        q.button    = bpc_pkg::BIDX_W'(btn);
        q.pin_level = pin;
        q.now_ms    = now;
        pending_queries.push_back(q);
        queries_queued++;
    endtask

    // Queue presses on one button followed by a release; return how many use a real action code.
    task automatic queue_press_sequence(logic [bpc_pkg::THR_W-1:0] thr,
                                        output int real_queries);
        int                         b;
        int                         presses;
        logic [1:0]                 main_action;
        logic [1:0]                 act;
        logic [bpc_pkg::TIME_W-1:0] t0;
        b            = $urandom_range(0, bpc_pkg::NUM_BUTTONS - 1);
        main_action  = 2'($urandom_range(0, 2));
        presses      = $urandom_range(1, 4);
        real_queries = 0;
        case ($urandom_range(0, 9))
            0:       t0 = '0;
            1:       t0 = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(thr));
            default: t0 = btn_clock[b] + $urandom_range(1, 3 * int'(thr) + 10);
        endcase
        for (int i = 0; i <= presses; i++)
        begin
            act = pick_action(main_action);
            add_query(act, b, (i == presses), (i == 0) ? t0 : t0 + near_threshold(thr));
            if (act != ACT_UNUSED)
                real_queries++;
        end
        btn_clock[b] = t0 + 2 * {16'd0, thr} + 2;
    endtask

    task automatic wait_drained();
        while (queries_accepted != queries_queued || results_seen != queries_accepted)
            @(posedge clk);
        // Let the pipeline settle before returning.
        repeat (3) @(posedge clk);
    endtask

    task automatic write_threshold(logic [bpc_pkg::THR_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_thr_ms = value;
        thresholds_used++;
    endtask

    task automatic run_random_phase(logic [bpc_pkg::THR_W-1:0] thr, int send_pct,
                                    int recv_pct);
        int counted;
        int seq_count;
        write_threshold(thr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        counted = 0;
        while (counted < QUERIES_PER_PHASE)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // Noise: any action, any button, any pin level, any time.
                add_query(2'($urandom_range(0, 3)),
                          $urandom_range(0, bpc_pkg::NUM_BUTTONS - 1),
                          1'($urandom_range(0, 1)), $urandom);
                counted++;
            end
            else
            begin
                queue_press_sequence(thr, seq_count);
                counted += seq_count;
            end
        end
    endtask

    // Driver: present the next pending query once the previous transfer is done.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_events.push_back(classify_query(in_flight));
                queries_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_queries.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_flight      = pending_queries.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, in_flight.now_ms, in_flight.pin_level,
                                      in_flight.button};
                    s_axis_tuser  <= in_flight.action;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest predicted event.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %02h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    expected_byte = {7'd0, expected_events.pop_front()};
                    if (m_axis_tdata !== expected_byte)
                    begin
                        $display("%0t: event mismatch, expected %02h, actual %02h",
                                 $time, expected_byte, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tdata[0] === 1'b1)
                        events_seen++;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Stopped after %0d accepted queries and %0d results: no transfer.",
                     queries_accepted, results_seen);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < bpc_pkg::NUM_BUTTONS; i++)
        begin
            btn_pressed[i] = 1'b0;
            btn_press_t[i] = '0;
            btn_held[i]    = 1'b0;
            btn_hold_t[i]  = '0;
            btn_clock[i]   = $urandom;
        end
        hold_thr_ms = bpc_pkg::THR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset threshold of 500 ms, no idling.
        add_query(ACT_UNUSED, 0, 1'b0, 32'hFFFF_FFFF);
        // Press edge fires once, then again only after a release.
        add_query(bpc_pkg::ACT_EDGE, 1, 1'b0, 32'd100);
        add_query(bpc_pkg::ACT_EDGE, 1, 1'b0, 32'd101);
        add_query(bpc_pkg::ACT_EDGE, 1, 1'b1, 32'd102);
        add_query(bpc_pkg::ACT_EDGE, 1, 1'b0, 32'd103);
        // Start seen at time zero stays unset; the next press records it.
        add_query(bpc_pkg::ACT_SHORT, 2, 1'b0, 32'd0);
        add_query(bpc_pkg::ACT_SHORT, 2, 1'b0, 32'd1000);
        add_query(bpc_pkg::ACT_SHORT, 2, 1'b1, 32'd1499);
        // Release without a press, then a press lasting exactly the threshold.
        add_query(bpc_pkg::ACT_SHORT, 3, 1'b1, 32'd5);
        add_query(bpc_pkg::ACT_SHORT, 3, 1'b0, 32'd2000);
        add_query(bpc_pkg::ACT_SHORT, 3, 1'b1, 32'd2500);
        // Held fires past the threshold, and not again until released.
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd3000);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd3500);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd3501);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd9000);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd9600);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b1, 32'd9700);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd10000);
        add_query(bpc_pkg::ACT_HELD, 4, 1'b0, 32'd10501);
        // Held across the wrap of the millisecond counter.
        add_query(bpc_pkg::ACT_HELD, 5, 1'b0, 32'hFFFF_FF00);
        add_query(bpc_pkg::ACT_HELD, 5, 1'b0, 32'h0000_0100);
        // Highest button, time at its top, short press across the wrap.
        add_query(bpc_pkg::ACT_EDGE, 7, 1'b0, 32'hFFFF_FFFF);
        add_query(bpc_pkg::ACT_SHORT, 7, 1'b0, 32'hFFFF_FFFF);
        add_query(bpc_pkg::ACT_SHORT, 7, 1'b1, 32'h0000_01F2);
        add_query(ACT_UNUSED, 7, 1'b1, 32'd0);

        // Random phases: threshold extremes and mid values, all four idle patterns.
        run_random_phase(16'd0,     0,  0);
        run_random_phase(16'd65535, 88, 0);
        run_random_phase(16'd1,     0,  88);
        run_random_phase(16'($urandom_range(2, 2000)), 29, 29);
        run_random_phase(16'd500,   0,  0);
        run_random_phase(16'($urandom_range(0, 65535)), 88, 0);
        run_random_phase(16'd37,    0,  88);
        run_random_phase(16'd65535, 29, 29);

        wait_drained();
        repeat (10) @(posedge clk);

        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d events still expected at the end, expected 0, actual %0d",
                     $time, expected_events.size(), expected_events.size());
            error_count += expected_events.size();
        end

        $display("Covered %0d queries on %0d buttons over %0d hold thresholds,",
                 queries_accepted, bpc_pkg::NUM_BUTTONS, thresholds_used);
        $display("with four idle patterns; %0d events reported, %0d mismatches.",
                 events_seen, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_ram.sv
rtl/button_press_classifier.sv
bench/tb_button_press_classifier.sv
